@@ rtl/core/checkerboard_window_mismatch_min_defines.svh @@
// Assertion macros shared by the checkerboard window mismatch RTL.
// Holds only macro definitions; no dependencies.
`ifndef CHECKERBOARD_WINDOW_MISMATCH_MIN_DEFINES_SVH
`define CHECKERBOARD_WINDOW_MISMATCH_MIN_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define CBWM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, when true, forces another one on the following edge.
`define CBWM_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

@@ rtl/core/cbwm_pkg.sv @@
// Shared constants, types and helper functions for the checkerboard window
// mismatch block. Used by the top level and the column history memory.
// No dependencies.
package cbwm_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int SIZE_W = 7;

  localparam int WIN          = 8;
  localparam int SLOT_W       = $clog2(WIN);
  localparam int HIST_W       = WIN - 1;
  localparam int CNT_W        = $clog2(WIN + 1);
  localparam int TOT_W        = 7;
  localparam int COST_W       = 6;
  localparam int WINDOW_CELLS = WIN * WIN;
  localparam int BEST_RESET   = WINDOW_CELLS / 2;
  localparam int SIZE_RESET   = 8;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } hist_rd_t;

  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [HIST_W-1:0] data;
  } hist_wr_t;

  // A size of zero acts as one, and sizes above the limit saturate.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] count_ones(input logic [HIST_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < HIST_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ rtl/core/cbwm_history.sv @@
// Per-column history of the last seven rows of mismatch bits.
// Synchronous memory with registered read data, write forwarding and
// per-entry valid bits. Depends on cbwm_pkg.
module cbwm_history (
  input  logic                            clk,
  input  logic                            rst,
  input  cbwm_pkg::hist_rd_t              rd,
  input  cbwm_pkg::hist_wr_t              wr,
  output logic [cbwm_pkg::HIST_W-1:0]     rd_data
);
  import cbwm_pkg::*;

  logic [HIST_W-1:0]   mem [MAX_COLS];
  logic [MAX_COLS-1:0] entry_valid;
  logic [HIST_W-1:0]   mem_q;
  logic                live_q;
  logic                fwd_q;
  logic [HIST_W-1:0]   fwd_data_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      mem_q      <= mem[rd.addr];
      fwd_data_q <= wr.data;
    end
  end

  // A write in the same cycle as a read of the same entry is forwarded,
  // since the array returns the old contents in that case.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      live_q      <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        live_q <= entry_valid[rd.addr];
        fwd_q  <= wr.en && (wr.addr == rd.addr);
      end
    end
  end

  assign rd_data = fwd_q ? fwd_data_q : (live_q ? mem_q : '0);

endmodule

@@ rtl/core/checkerboard_window_mismatch_min.sv @@
// Top level of the checkerboard window mismatch block.
// Depends on cbwm_pkg, cbwm_history and the assertion macro header.
//
// The block takes a binary image one pixel per transaction in raster order
// and, on the last pixel of each frame, returns one result transaction with
// the least number of cells that must be repainted so that some 8x8 window
// becomes a proper checkerboard of either start color, or flags no_window
// when the frame is smaller than 8x8. It sustains one pixel per clock cycle:
// each pixel needs exactly one read and one write of the column history
// memory, and that single read port and single write port set the rate.
// A pixel passes through the processing stage after it is accepted, and the
// result is registered when the frame's last pixel retires from it. Input is
// stalled only while a finished result waits in the output register and the
// next frame's last pixel is ready to retire behind it. The history memory
// needs no clearing pass after reset; per-entry valid bits make unwritten
// columns read as zero. Frame sizes are written through the configuration
// port, which is always ready; any write to a known register restarts the
// frame, and writes are expected only while the block is idle.
`include "checkerboard_window_mismatch_min_defines.svh"

module checkerboard_window_mismatch_min (
  input  logic                              clk,
  input  logic                              rst,
  // Pixel channel.
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic                              pixel_black,
  // Result channel.
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [cbwm_pkg::COST_W-1:0]       min_repaint,
  output logic                              no_window,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbwm_pkg::SIZE_W-1:0]       cfg_data
);
  import cbwm_pkg::*;

  // Configuration registers and their effective, clamped values.
  logic [SIZE_W-1:0] frame_rows;
  logic [SIZE_W-1:0] frame_cols;
  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;

  // Position of the next pixel to be accepted.
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;

  // Processing stage: one pixel whose history read is in flight.
  logic             s1_valid;
  logic             s1_bit;
  logic [COL_W-1:0] s1_col;
  logic             s1_in_window;
  logic             s1_last;

  // Running window state.
  logic [CNT_W-1:0]  column_counts [WIN];
  logic [TOT_W-1:0]  window_total;
  logic [COST_W-1:0] best_count;
  logic              window_seen;

  logic pixel_acc;
  logic cfg_wr;
  logic cfg_known;
  logic col_end;
  logic row_end;
  logic s1_retire;

  logic [HIST_W-1:0] hist;
  logic [CNT_W-1:0]  colsum;
  logic [SLOT_W-1:0] slot;
  logic [TOT_W-1:0]  total_base;
  logic [TOT_W-1:0]  total_next;
  logic [TOT_W-1:0]  clipped;
  logic [TOT_W-1:0]  other;
  logic [TOT_W-1:0]  cost_full;
  logic [COST_W-1:0] cost;
  logic [COST_W-1:0] best_next;
  logic              seen_next;

  hist_rd_t hist_rd;
  hist_wr_t hist_wr;

  assign rows_eff = clamp_size(frame_rows, SIZE_W'(MAX_ROWS));
  assign cols_eff = clamp_size(frame_cols, SIZE_W'(MAX_COLS));

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == REG_FRAME_ROWS) || (cfg_index == REG_FRAME_COLS);

  // The stage retires unless it holds a frame's last pixel and the result
  // register is still occupied by an untaken result.
  assign s1_retire   = s1_valid && (!s1_last || !result_valid || !result_stall);
  assign pixel_stall = s1_valid && !s1_retire;
  assign pixel_acc   = pixel_valid && !pixel_stall;

  assign col_end = (SIZE_W'(col_pos) + SIZE_W'(1)) >= cols_eff;
  assign row_end = (SIZE_W'(row_pos) + SIZE_W'(1)) >= rows_eff;

  // The history memory is read when a pixel is accepted and written back
  // when it retires from the processing stage.
  assign hist_rd.en   = pixel_acc;
  assign hist_rd.addr = col_pos;
  assign hist_wr.en   = s1_retire;
  assign hist_wr.addr = s1_col;
  assign hist_wr.data = {hist[HIST_W-2:0], s1_bit};

  cbwm_history u_history (
    .clk     (clk),
    .rst     (rst),
    .rd      (hist_rd),
    .wr      (hist_wr),
    .rd_data (hist)
  );

  // Column sum over eight rows, then the sliding sum over eight columns.
  // The sum restarts at the first column of every row.
  always_comb begin
    colsum = count_ones(hist) + CNT_W'(s1_bit);
    slot   = s1_col[SLOT_W-1:0];
    if (s1_col == '0) begin
      total_base = '0;
    end else if (s1_col >= COL_W'(WIN)) begin
      total_base = window_total - TOT_W'(column_counts[slot]);
    end else begin
      total_base = window_total;
    end
    total_next = total_base + TOT_W'(colsum);

    // A window costs the smaller of its mismatches and its matches, which
    // covers both possible start colors.
    clipped   = (total_next > TOT_W'(WINDOW_CELLS)) ? TOT_W'(WINDOW_CELLS) : total_next;
    other     = TOT_W'(WINDOW_CELLS) - clipped;
    cost_full = (clipped < other) ? clipped : other;
    cost      = cost_full[COST_W-1:0];

    best_next = (s1_in_window && (cost < best_count)) ? cost : best_count;
    seen_next = window_seen || s1_in_window;
  end

  always_ff @(posedge clk) begin
    if (pixel_acc) begin
      s1_bit       <= pixel_black ^ row_pos[0] ^ col_pos[0];
      s1_col       <= col_pos;
      s1_in_window <= (row_pos >= ROW_W'(WIN - 1)) && (col_pos >= COL_W'(WIN - 1));
      s1_last      <= row_end && col_end;
    end
    if (s1_retire && s1_last) begin
      min_repaint <= seen_next ? best_next : '0;
      no_window   <= !seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows   <= SIZE_W'(SIZE_RESET);
      frame_cols   <= SIZE_W'(SIZE_RESET);
      row_pos      <= '0;
      col_pos      <= '0;
      s1_valid     <= 1'b0;
      window_total <= '0;
      best_count   <= COST_W'(BEST_RESET);
      window_seen  <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < WIN; i++) begin
        column_counts[i] <= '0;
      end
    end else begin
      // Position advances as each pixel is accepted.
      if (pixel_acc) begin
        if (row_end && col_end) begin
          row_pos <= '0;
          col_pos <= '0;
        end else if (col_end) begin
          row_pos <= row_pos + ROW_W'(1);
          col_pos <= '0;
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
      end

      if (pixel_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_retire) begin
        s1_valid <= 1'b0;
      end

      if (s1_retire) begin
        column_counts[slot] <= colsum;
        if (s1_last) begin
          window_total <= '0;
          best_count   <= COST_W'(BEST_RESET);
          window_seen  <= 1'b0;
        end else begin
          window_total <= total_next;
          best_count   <= best_next;
          window_seen  <= seen_next;
        end
      end

      if (s1_retire && s1_last) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // A write to a known register restarts the frame.
      if (cfg_wr) begin
        case (cfg_index)
          REG_FRAME_ROWS: frame_rows <= cfg_data;
          REG_FRAME_COLS: frame_cols <= cfg_data;
          default: ;
        endcase
        if (cfg_known) begin
          row_pos      <= '0;
          col_pos      <= '0;
          window_total <= '0;
          best_count   <= COST_W'(BEST_RESET);
          window_seen  <= 1'b0;
        end
      end
    end
  end

  `CBWM_ASSERT(a_result_range, clk, rst, result_valid |-> (min_repaint <= COST_W'(BEST_RESET)), "min_repaint above half a window")
  `CBWM_ASSERT(a_no_window_zero, clk, rst, (result_valid && no_window) |-> (min_repaint == '0), "no_window result carries a nonzero count")
  `CBWM_ASSERT(a_total_range, clk, rst, window_total <= TOT_W'(WINDOW_CELLS), "window sum exceeds window size")
  `CBWM_ASSERT_NEXT(a_frame_wrap, clk, rst, pixel_acc && row_end && col_end, (row_pos == '0) && (col_pos == '0), "position did not wrap at frame end")

endmodule
